@@ hw/rtl/sha256_pkg.sv @@
// sha-256 hasher package: types, constants and round functions
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;
	localparam int unsigned QueueDepth = 4;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} core_state_t;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [255:0] INIT_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
			endcase
			return k;
		end
	endfunction

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/sha256_fifo.sv @@
// request queue between the front end and the hashing core
`timescale 1ns / 1ps
`default_nettype none
module sha256_fifo
	import sha256_pkg::*;
#(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       push,
	input  wire req_t push_data,
	output logic      full,
	input  wire       pop,
	output req_t      pop_data,
	output logic      empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	req_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign full     = (cnt_q == (AW+1)'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/sha256_core.sv @@
// hashing core: block assembly, padding, 64-round compression and digest output
`timescale 1ns / 1ps
`default_nettype none
module sha256_core
	import sha256_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         req_valid,
	input  wire req_t   req,
	output logic        req_pop,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] out_word,
	output logic [2:0]  out_index,
	output logic        out_last,
	output logic        busy
);
	core_state_t state_q, state_d;
	logic [7:0]   blk_q [64];
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [16];
	logic [5:0]   rnd_q;
	logic         fin_q;   // finishing run in progress
	logic         pad2_q;  // a second padding block is still due
	logic [2:0]   idx_q;
	logic [63:0]  total_q;

	// round datapath
	logic [31:0] t1, t2, s0w, s1w, wnew, wcur;
	always_comb begin
		wcur = w_q[0];
		s0w  = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
		s1w  = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0w + w_q[9] + s1w;
		t1   = v_q[7] + (ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + wcur;
		t2   = (ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	logic start_blk, start_pad;
	always_comb begin
		state_d   = state_q;
		req_pop   = 1'b0;
		start_blk = 1'b0;
		start_pad = 1'b0;
		unique case (state_q)
		ST_IDLE: begin
			if (req_valid) begin
				req_pop = 1'b1;
				if (req.op == OP_ABSORB) begin
					if (fill_q == 6'd63) begin
						start_blk = 1'b1;
						state_d   = ST_ROUND;
					end
				end else begin
					start_pad = 1'b1;
					state_d   = ST_ROUND;
				end
			end
		end
		ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
		ST_ADD:   state_d = (fin_q && !pad2_q) ? ST_EMIT : (fin_q ? ST_ROUND : ST_IDLE);
		ST_EMIT:  if (out_ready && idx_q == 3'd7) state_d = ST_IDLE;
		default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// padded block image as bytes; built from the finishing position
	function automatic logic [7:0] pad_byte(input logic [5:0] p, input logic [5:0] f,
		input logic [7:0] b, input logic lenblk, input logic [63:0] tot);
		logic [7:0] r;
		begin
			if (p < f)       r = b;
			else if (p == f) r = 8'h80;
			else             r = 8'h00;
			if (lenblk && p >= 6'd56) r = tot[8*(63-p) +: 8];
			return r;
		end
	endfunction

	logic [63:0] tot_now;
	logic        two_blk;
	assign tot_now = bits_q + {55'd0, fill_q, 3'd0};
	assign two_blk = (fill_q > 6'd55);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
			rnd_q  <= '0;
			fin_q  <= 1'b0;
			pad2_q <= 1'b0;
			idx_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[255-32*i -: 32];
		end else begin
			if (state_q == ST_IDLE && req_valid) begin
				if (req.op == OP_ABSORB) begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == 6'd63) bits_q <= bits_q + 64'd512;
				end else begin
					fin_q  <= 1'b1;
					pad2_q <= two_blk;
				end
			end
			if (state_q == ST_ROUND) rnd_q <= rnd_q + 1'b1;
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				if (pad2_q) pad2_q <= 1'b0;
			end
			if (state_q == ST_EMIT && out_ready) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == 3'd7) begin
					fin_q  <= 1'b0;
					fill_q <= '0;
					bits_q <= '0;
					for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[255-32*i -: 32];
				end
			end
		end
	end

	// block bytes, round state and message schedule
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid && req.op == OP_ABSORB)
			blk_q[fill_q] <= req.data_byte;
		if (start_blk || start_pad || (state_q == ST_ADD && fin_q && pad2_q)) begin
			for (int i = 0; i < 8; i++) v_q[i] <= (state_q == ST_ADD) ? h_q[i] + v_q[i] : h_q[i];
			for (int j = 0; j < 16; j++) begin
				for (int k = 0; k < 4; k++) begin
					logic [5:0] p;
					logic [7:0] b;
					p = 6'(4*j + k);
					if (start_blk)
						b = (p == 6'd63) ? req.data_byte : blk_q[p];
					else if (start_pad)
						b = pad_byte(p, fill_q, blk_q[p], !two_blk, tot_now);
					else
						b = (p >= 6'd56) ? total_q[8*(63-p) +: 8] : 8'h00;
					w_q[j][31-8*k -: 8] <= b;
				end
			end
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
			w_q[15] <= wnew;
		end
		if (start_pad) total_q <= tot_now;
	end

	assign out_valid = (state_q == ST_EMIT);
	assign out_word  = h_q[idx_q];
	assign out_index = idx_q;
	assign out_last  = (idx_q == 3'd7);
	assign busy      = (state_q != ST_IDLE);
endmodule
`default_nettype wire

@@ hw/rtl/sha256_byte_stream_hasher.sv @@
// top level of the sha-256 byte stream hasher
// an absorb is stored in the block buffer; one that fills a block loads it, then runs
// 64 rounds, one per cycle, and an add; a finish runs one or two padded blocks that way,
// then emits the 8 digest words; the queue registers each request before the core sees it
// requests wait while a block is compressed in the single shared round unit
// reset: arst_n clears queue, counters and state and loads the initial hash values
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher
	import sha256_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // data_byte
	input  wire         s_tuser,   // op
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // digest_word [31:0], word_index [34:32], zero fill
	output logic        m_tlast    // last
);
	req_t in_req, q_req;
	logic full, empty, pop, busy;
	logic [31:0] word;
	logic [2:0]  index;

	// front end: classify each request into the queue
	assign in_req.op        = s_tuser;
	assign in_req.data_byte = s_tdata;
	assign s_tready         = !full;

	sha256_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(s_tvalid), .push_data(in_req), .full(full),
		.pop(pop), .pop_data(q_req), .empty(empty)
	);

	// back end: compression and digest output
	sha256_core u_core (
		.clk(clk), .arst_n(arst_n),
		.req_valid(!empty), .req(q_req), .req_pop(pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_word(word), .out_index(index), .out_last(m_tlast),
		.busy(busy)
	);

	assign m_tdata = {5'd0, index, word};

	// the core only takes requests when idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !busy)
		else $error("request taken while core busy");
	// last marks only the final digest word
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[34:32] == 3'd7)
		else $error("last on wrong word");
	// word index steps after each delivered word
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast
		|=> m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)
		else $error("digest word order broken");
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the sha-256 byte stream hasher
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import sha256_pkg::*;

	localparam int unsigned CycleLimit = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	req_t         pending_reqs[$];
	digest_beat_t expected_beats[$];

	// predictor copy of the hasher state
	logic [7:0]  blk[64];
	int unsigned fill;
	logic [63:0] msg_bits;
	logic [31:0] hw[8];

	int unsigned mismatches;
	int unsigned beats_seen;
	int unsigned reqs_sent;
	int unsigned messages;
	int unsigned cycles;
	bit          no_idle;

	sha256_byte_stream_hasher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] k_const(input int i);
		logic [31:0] k[64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
			32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
			32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
			32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
			32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
			32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
			32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
			32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
			32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[i];
	endfunction

	function automatic void load_initial_hash();
		for (int i = 0; i < 8; i++) hw[i] = INIT_HASH[255 - 32 * i -: 32];
	endfunction

	// one 64-round compression of blk into hw
	function automatic void compress_block();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i - 15], 7) ^ rotr(w[i - 15], 18) ^ (w[i - 15] >> 3);
			s1 = rotr(w[i - 2], 17) ^ rotr(w[i - 2], 19) ^ (w[i - 2] >> 10);
			w[i] = w[i - 16] + s0 + w[i - 7] + s1;
		end
		v = hw;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(i) + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hw[i] = hw[i] + v[i];
	endfunction

	// advance the predictor by one accepted request, queueing any digest words
	function automatic void predict_digest(input req_t r);
		int unsigned p;
		logic [63:0] total;
		digest_beat_t b;
		if (r.op == OP_ABSORB) begin
			blk[fill] = r.data_byte;
			fill++;
			if (fill == 64) begin
				compress_block();
				msg_bits += 64'd512;
				fill = 0;
			end
			return;
		end
		p = fill;
		blk[p] = 8'h80;
		p++;
		// 0x80 past byte 55 needs an extra block for the length
		if (p > 56) begin
			while (p < 64) blk[p++] = 8'h00;
			compress_block();
			p = 0;
		end
		while (p < 56) blk[p++] = 8'h00;
		total = msg_bits + 64'(fill) * 64'd8;
		for (int i = 0; i < 8; i++) blk[63 - i] = total[8 * i +: 8];
		compress_block();
		for (int i = 0; i < 8; i++) begin
			b.word = hw[i];
			b.index = 3'(i);
			b.last = (i == 7);
			expected_beats = {expected_beats, b};
		end
		fill = 0;
		msg_bits = '0;
		load_initial_hash();
		messages++;
	endfunction

	function automatic void add_message(input int unsigned len, input bit fixed_val,
			input logic [7:0] val);
		req_t r;
		for (int unsigned i = 0; i < len; i++) begin
			r.op = OP_ABSORB;
			r.data_byte = fixed_val ? val : 8'($urandom);
			pending_reqs = {pending_reqs, r};
		end
		r.op = OP_FINISH;
		r.data_byte = 8'($urandom);
		pending_reqs = {pending_reqs, r};
	endfunction

	// driver: takes requests from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_digest(req_t'{op: s_tuser, data_byte: s_tdata});
				reqs_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
					s_tvalid <= 1'b1;
					s_tuser  <= pending_reqs[0].op;
					s_tdata  <= pending_reqs[0].data_byte;
					void'(pending_reqs.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure and digest check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				beats_seen++;
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected digest word %h index %0d last %b",
							m_tdata[31:0], m_tdata[34:32], m_tlast);
				end else begin
					digest_beat_t e;
					e = expected_beats.pop_front();
					if (m_tdata[31:0] !== e.word || m_tdata[34:32] !== e.index
							|| m_tlast !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
								e.word, e.index, e.last,
								m_tdata[31:0], m_tdata[34:32], m_tlast);
					end
				end
			end
			m_tready <= no_idle || ($urandom_range(99) >= 37);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		req_t r;
		int unsigned len;
		arst_n = 1'b0;
		fill = 0;
		msg_bits = '0;
		load_initial_hash();
		for (int i = 0; i < 64; i++) blk[i] = '0;
		mismatches = 0; beats_seen = 0; reqs_sent = 0; messages = 0; cycles = 0;
		no_idle = 0;

		// directed: empty message, byte extremes, padding boundaries 55/56/64
		add_message(0, 0, 8'h00);
		add_message(1, 1, 8'h00);
		add_message(1, 1, 8'hff);
		add_message(2, 0, 8'h00);
		r.op = OP_FINISH; r.data_byte = 8'hff;
		pending_reqs = {pending_reqs, r};
		add_message(55, 0, 8'h00);
		add_message(56, 0, 8'h00);
		add_message(64, 0, 8'h00);

		// random messages, mostly short, some crossing a block
		for (int m = 0; m < 10; m++) begin
			len = ($urandom_range(3) == 0) ? $urandom_range(70) : $urandom_range(8);
			add_message(len, 0, 8'h00);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// idle-free stretch in the middle of the run
		wait (reqs_sent > 100);
		@(posedge clk);
		no_idle <= 1'b1;
		wait (reqs_sent > 200 || pending_reqs.size() == 0);
		@(posedge clk);
		no_idle <= 1'b0;

		wait (pending_reqs.size() == 0 && !s_tvalid);
		wait (expected_beats.size() == 0);
		repeat (200) @(posedge clk);
		$display("sent %0d requests over %0d messages, checked %0d digest words",
			reqs_sent, messages, beats_seen);
		if (mismatches == 0 && expected_beats.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_fifo.sv
hw/rtl/sha256_core.sv
hw/rtl/sha256_byte_stream_hasher.sv
tb/tb.sv
